>>> rtl/core/lrwi_pkg.sv
// ----------------------------------------------------------------------------
// lrwi_pkg: ramp window interpolator shared definitions
// Widths, window constants, sequencer states and edge mapping.
// ----------------------------------------------------------------------------
package lrwi_pkg;

  localparam int LEVEL_W  = 8;
  localparam int LEN_W    = 7;
  localparam int CUR_W    = 16;
  localparam int EDGE_W   = 8;
  localparam int DELTA_W  = LEVEL_W + 1;
  localparam int PROD_W   = LEVEL_W + LEN_W;
  localparam int ALU_W    = CUR_W;
  localparam int MUL_STEPS = LEN_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);

  localparam logic [CUR_W-1:0]  LEVEL_MAX      = CUR_W'(79);
  localparam logic [EDGE_W-1:0] PRIMARY_OOR    = EDGE_W'(200);
  localparam logic [EDGE_W-1:0] SECONDARY_OOR  = EDGE_W'(250);
  localparam logic [EDGE_W-1:0] SECONDARY_BASE = EDGE_W'(159);

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ARM  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [EDGE_W-1:0] primary;
    logic [EDGE_W-1:0] secondary;
  } edges_t;

  function automatic edges_t map_edges(input logic [CUR_W-1:0] lvl);
    edges_t e;
    if (lvl > LEVEL_MAX) begin
      e.primary   = PRIMARY_OOR;
      e.secondary = SECONDARY_OOR;
    end else begin
      e.primary   = lvl[EDGE_W-1:0];
      e.secondary = SECONDARY_BASE - lvl[EDGE_W-1:0];
    end
    return e;
  endfunction

endpackage

>>> rtl/core/lrwi_in_if.sv
// ----------------------------------------------------------------------------
// lrwi_in_if: input channel
// Valid/ready channel carrying one arm or tick beat.
// ----------------------------------------------------------------------------
interface lrwi_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [lrwi_pkg::LEVEL_W-1:0] start_level;
  logic signed [lrwi_pkg::LEVEL_W-1:0] end_level;
  logic        [lrwi_pkg::LEN_W-1:0]   duration_ticks;

  modport source (output valid, mode, start_level, end_level, duration_ticks, input ready);
  modport sink   (input valid, mode, start_level, end_level, duration_ticks, output ready);
endinterface

>>> rtl/core/lrwi_out_if.sv
// ----------------------------------------------------------------------------
// lrwi_out_if: result channel
// Valid/ready channel carrying the two window edges and the done flag.
// ----------------------------------------------------------------------------
interface lrwi_out_if;
  logic                              valid;
  logic                              ready;
  logic [lrwi_pkg::EDGE_W-1:0]       primary_edge;
  logic [lrwi_pkg::EDGE_W-1:0]       secondary_edge;
  logic                              ramp_done;

  modport source (output valid, primary_edge, secondary_edge, ramp_done, input ready);
  modport sink   (input valid, primary_edge, secondary_edge, ramp_done, output ready);
endinterface

>>> rtl/core/linear_ramp_window_interpolator_top.sv
// ----------------------------------------------------------------------------
// linear_ramp_window_interpolator_top: frame-ticked ramp to window edges
// Arm beats load a ramp; tick beats advance it with a shared-adder
// shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   in_ch    in   mode, start_level, end_level, duration_ticks
//   out_ch   out  primary_edge, secondary_edge, ramp_done
//
// Arm, idle and finishing ticks go from accept through ST_OUT to the result.
// Advancing tick: accept, then multiply (ST_MUL), divide (ST_DIV), add (ST_ADD)
// and load in ST_OUT, all on one 16-bit adder under the sequencer.
// rst_n is synchronous; ramp state and level clear to zero.
// in_ch.ready is high only in idle; a waiting result stalls the load only.
// ----------------------------------------------------------------------------
module linear_ramp_window_interpolator_top (
  input  logic             clk,
  input  logic             rst_n,
  lrwi_in_if.sink          in_ch,
  lrwi_out_if.source       out_ch
);

  localparam int LW = lrwi_pkg::LEVEL_W;
  localparam int NW = lrwi_pkg::LEN_W;
  localparam int CW = lrwi_pkg::CUR_W;
  localparam int PW = lrwi_pkg::PROD_W;
  localparam int AW = lrwi_pkg::ALU_W;
  localparam int DW = lrwi_pkg::DELTA_W;
  localparam int KW = lrwi_pkg::CNT_W;

  lrwi_pkg::state_t        state_r, state_nxt;
  logic signed [LW-1:0]    start_r, start_nxt;
  logic signed [LW-1:0]    end_r, end_nxt;
  logic [NW-1:0]           len_r, len_nxt;
  logic [NW-1:0]           step_r, step_nxt;
  logic [CW-1:0]           level_r, level_nxt;
  logic [PW-1:0]           acc_r, acc_nxt;
  logic [PW-1:0]           mcand_r, mcand_nxt;
  logic [NW-1:0]           mplier_r, mplier_nxt;
  logic [NW-1:0]           rem_r, rem_nxt;
  logic [KW-1:0]           cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic                    done_r, done_nxt;
  logic                    out_valid_r, out_valid_nxt;
  lrwi_pkg::edges_t        edges_r, edges_nxt;
  logic                    out_done_r, out_done_nxt;

  logic                    accept;
  logic signed [DW-1:0]    delta;
  logic [DW-1:0]           delta_mag;
  logic [NW:0]             rem_sh;
  logic [AW-1:0]           alu_a, alu_b;
  logic                    alu_cin;
  logic [AW:0]             alu_sum;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == lrwi_pkg::ST_IDLE);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.primary_edge   = edges_r.primary;
  assign out_ch.secondary_edge = edges_r.secondary;
  assign out_ch.ramp_done      = out_done_r;

  assign delta     = DW'(end_r) - DW'(start_r);
  assign delta_mag = delta[DW-1] ? DW'(-delta) : DW'(delta);
  assign rem_sh    = {rem_r, acc_r[PW-1]};

  // shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state_r)
      lrwi_pkg::ST_MUL: begin
        alu_a = AW'(acc_r);
        alu_b = mplier_r[0] ? AW'(mcand_r) : '0;
      end
      lrwi_pkg::ST_DIV: begin
        alu_a   = AW'(rem_sh);
        alu_b   = ~AW'(len_r);
        alu_cin = 1'b1;
      end
      lrwi_pkg::ST_ADD: begin
        alu_a   = AW'(start_r);
        alu_b   = neg_r ? ~AW'(acc_r) : AW'(acc_r);
        alu_cin = neg_r;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (AW + 1)'(alu_cin);
  end

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    len_nxt       = len_r;
    step_nxt      = step_r;
    level_nxt     = level_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    edges_nxt     = edges_r;
    out_done_nxt  = out_done_r;
    case (state_r)
      lrwi_pkg::ST_IDLE: begin
        if (accept) begin
          done_nxt  = 1'b0;
          state_nxt = lrwi_pkg::ST_OUT;
          if (in_ch.mode == lrwi_pkg::MODE_ARM) begin
            start_nxt = in_ch.start_level;
            end_nxt   = in_ch.end_level;
            len_nxt   = in_ch.duration_ticks;
            step_nxt  = '0;
          end else if (len_r != '0) begin
            if (step_r >= len_r) begin
              len_nxt  = '0;
              done_nxt = 1'b1;
            end else begin
              step_nxt   = step_r + NW'(1);
              mplier_nxt = step_r + NW'(1);
              mcand_nxt  = PW'(delta_mag);
              neg_nxt    = delta[DW-1];
              acc_nxt    = '0;
              cnt_nxt    = '0;
              state_nxt  = lrwi_pkg::ST_MUL;
            end
          end
        end
      end
      lrwi_pkg::ST_MUL: begin
        acc_nxt    = alu_sum[PW-1:0];
        mcand_nxt  = {mcand_r[PW-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[NW-1:1]};
        cnt_nxt    = cnt_r + KW'(1);
        if (cnt_r == KW'(lrwi_pkg::MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = lrwi_pkg::ST_DIV;
        end
      end
      lrwi_pkg::ST_DIV: begin
        // carry out set means rem_sh >= len
        if (alu_sum[AW]) begin
          rem_nxt = alu_sum[NW-1:0];
        end else begin
          rem_nxt = rem_sh[NW-1:0];
        end
        acc_nxt = {acc_r[PW-2:0], alu_sum[AW]};
        cnt_nxt = cnt_r + KW'(1);
        if (cnt_r == KW'(lrwi_pkg::DIV_STEPS - 1)) begin
          state_nxt = lrwi_pkg::ST_ADD;
        end
      end
      lrwi_pkg::ST_ADD: begin
        level_nxt = alu_sum[CW-1:0];
        state_nxt = lrwi_pkg::ST_OUT;
      end
      lrwi_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          edges_nxt     = lrwi_pkg::map_edges(level_r);
          out_done_nxt  = done_r;
          state_nxt     = lrwi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrwi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrwi_pkg::ST_IDLE;
      start_r     <= '0;
      end_r       <= '0;
      len_r       <= '0;
      step_r      <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      len_r       <= len_nxt;
      step_r      <= step_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    done_r     <= done_nxt;
    edges_r    <= edges_nxt;
    out_done_r <= out_done_nxt;
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> (step_r <= len_r))
    else $error("step count beyond ramp length");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrwi_pkg::ST_DIV && cnt_r != '0) |-> (rem_r < len_r))
    else $error("divide remainder not below divisor");

  a_edge_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((edges_r.primary == lrwi_pkg::PRIMARY_OOR &&
                      edges_r.secondary == lrwi_pkg::SECONDARY_OOR) ||
                     (edges_r.primary + edges_r.secondary ==
                      lrwi_pkg::SECONDARY_BASE)))
    else $error("window edges inconsistent");

  a_done_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrwi_pkg::ST_OUT && done_r) |-> (len_r == '0))
    else $error("done flagged on a live ramp");

endmodule

>>> verif/linear_ramp_window_interpolator_top_tb.sv
// ----------------------------------------------------------------------------
// linear_ramp_window_interpolator_top_tb: ramp window interpolator testbench
// Drives arm and tick beats with bursty timing against a stalling receiver,
// predicts every result from its own model of the ramp state and checks the
// window edges and the done flag of each result beat in order.
// ----------------------------------------------------------------------------
module linear_ramp_window_interpolator_top_tb;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BEATS = 400;
  localparam int MAX_REPORTS  = 10;

  class window_edge_scoreboard;
    typedef struct {
      logic [lrwi_pkg::EDGE_W-1:0] primary;
      logic [lrwi_pkg::EDGE_W-1:0] secondary;
      logic                        done;
    } edge_beat_t;

    logic signed [lrwi_pkg::LEVEL_W-1:0] ramp_start;
    logic signed [lrwi_pkg::LEVEL_W-1:0] ramp_end;
    logic [lrwi_pkg::LEN_W-1:0]          ramp_length;
    logic [lrwi_pkg::LEN_W-1:0]          step_count;
    logic [lrwi_pkg::CUR_W-1:0]          level;
    edge_beat_t                          expected_edges[$];
    int                                  mismatches;
    int                                  results;
    int                                  arms;
    int                                  finishes;
    int                                  out_of_range;

    function new();
      ramp_start  = '0;
      ramp_end    = '0;
      ramp_length = '0;
      step_count  = '0;
      level       = '0;
      mismatches  = 0;
      results     = 0;
      arms        = 0;
      finishes    = 0;
      out_of_range = 0;
    endfunction

    function void note_beat(logic mode, logic signed [lrwi_pkg::LEVEL_W-1:0] s,
                            logic signed [lrwi_pkg::LEVEL_W-1:0] e,
                            logic [lrwi_pkg::LEN_W-1:0] d);
      edge_beat_t exp_beat;
      int         delta;
      int         quot;
      exp_beat.done = 1'b0;
      if (mode == lrwi_pkg::MODE_ARM) begin
        ramp_start  = s;
        ramp_end    = e;
        ramp_length = d;
        step_count  = '0;
        arms++;
      end else if (ramp_length != 0) begin
        if (step_count >= ramp_length) begin
          ramp_length   = '0;
          exp_beat.done = 1'b1;
        end else begin
          step_count = step_count + 1'b1;
          delta = int'(ramp_end) - int'(ramp_start);
          quot  = (delta * int'(step_count)) / int'(ramp_length);
          level = lrwi_pkg::CUR_W'(int'(ramp_start) + quot);
        end
      end
      if (level > lrwi_pkg::LEVEL_MAX) begin
        exp_beat.primary   = lrwi_pkg::PRIMARY_OOR;
        exp_beat.secondary = lrwi_pkg::SECONDARY_OOR;
      end else begin
        exp_beat.primary   = level[lrwi_pkg::EDGE_W-1:0];
        exp_beat.secondary = lrwi_pkg::SECONDARY_BASE - level[lrwi_pkg::EDGE_W-1:0];
      end
      expected_edges.push_back(exp_beat);
    endfunction

    function void check_beat(logic [lrwi_pkg::EDGE_W-1:0] p,
                             logic [lrwi_pkg::EDGE_W-1:0] s, logic d);
      edge_beat_t exp_beat;
      results++;
      if (expected_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: unexpected result primary=%0d secondary=%0d done=%0b",
                   p, s, d);
        return;
      end
      exp_beat = expected_edges.pop_front();
      if (exp_beat.done) finishes++;
      if (exp_beat.primary == lrwi_pkg::PRIMARY_OOR) out_of_range++;
      if (p !== exp_beat.primary || s !== exp_beat.secondary || d !== exp_beat.done) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"mismatch at result %0d: primary exp %0d got %0d, ",
                    "secondary exp %0d got %0d, done exp %0b got %0b"},
                   results, exp_beat.primary, p, exp_beat.secondary, s,
                   exp_beat.done, d);
      end
    endfunction

    function int pending();
      return expected_edges.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic hold_req = 1'b0;
  int   holds_done = 0;
  int   beats_sent = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;

  window_edge_scoreboard sb = new();

  lrwi_in_if  in_ch();
  lrwi_out_if out_ch();

  linear_ramp_window_interpolator_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_beat(in_ch.mode, in_ch.start_level, in_ch.end_level, in_ch.duration_ticks);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_beat(out_ch.primary_edge, out_ch.secondary_edge, out_ch.ramp_done);
  end

  // stall watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no beat accepted for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: changing stall styles, plus one long hold-off on request
  initial begin
    int style;
    int left;
    style = 0;
    left  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      if (left == 0) begin
        style = $urandom_range(0, 2);
        left  = $urandom_range(20, 80);
      end
      left--;
      case (style)
        0:       out_ch.ready = 1'b1;
        1:       out_ch.ready = 1'($urandom_range(0, 1));
        default: out_ch.ready = ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  task automatic send_beat(logic mode, logic [lrwi_pkg::LEVEL_W-1:0] s,
                           logic [lrwi_pkg::LEVEL_W-1:0] e,
                           logic [lrwi_pkg::LEN_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_ch.valid          = 1'b1;
    in_ch.mode           = mode;
    in_ch.start_level    = s;
    in_ch.end_level      = e;
    in_ch.duration_ticks = d;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_tick();
    send_beat(lrwi_pkg::MODE_TICK, lrwi_pkg::LEVEL_W'($urandom),
              lrwi_pkg::LEVEL_W'($urandom), lrwi_pkg::LEN_W'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // arm with random content, then ticks through (or short of) the end
  task automatic send_ramp_run();
    logic [lrwi_pkg::LEVEL_W-1:0] s;
    logic [lrwi_pkg::LEVEL_W-1:0] e;
    logic [lrwi_pkg::LEN_W-1:0]   d;
    int                           pick;
    int                           n;
    pick = $urandom_range(0, 99);
    if (pick < 10)      d = '0;
    else if (pick < 75) d = lrwi_pkg::LEN_W'($urandom_range(1, 8));
    else if (pick < 95) d = lrwi_pkg::LEN_W'($urandom_range(9, 40));
    else                d = lrwi_pkg::LEN_W'($urandom_range(100, 127));
    if ($urandom_range(0, 9) < 6) begin
      s = lrwi_pkg::LEVEL_W'(int'($urandom_range(0, 100)) - 10);
      e = lrwi_pkg::LEVEL_W'(int'($urandom_range(0, 100)) - 10);
    end else begin
      s = lrwi_pkg::LEVEL_W'($urandom);
      e = lrwi_pkg::LEVEL_W'($urandom);
    end
    send_beat(lrwi_pkg::MODE_ARM, s, e, d);
    if ($urandom_range(0, 4) == 0) n = $urandom_range(0, d);
    else                           n = int'(d) + 1 + $urandom_range(0, 2);
    repeat (n) send_tick();
  endtask

  initial begin
    int  target;
    bit  drained_mid;
    in_ch.valid          = 1'b0;
    in_ch.mode           = lrwi_pkg::MODE_TICK;
    in_ch.start_level    = '0;
    in_ch.end_level      = '0;
    in_ch.duration_ticks = '0;
    drained_mid = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: idle, zero duration, edges of the window, truncation, re-arm
    send_beat(lrwi_pkg::MODE_TICK, 8'h7F, 8'h80, 7'h7F);
    send_beat(lrwi_pkg::MODE_ARM,  8'd0,  8'd0,  7'd0);
    send_beat(lrwi_pkg::MODE_TICK, 8'h00, 8'hFF, 7'h00);
    send_beat(lrwi_pkg::MODE_ARM,  8'd0,  8'd79, 7'd1);
    send_tick();
    send_tick();
    send_tick();
    send_beat(lrwi_pkg::MODE_ARM,  8'd79, 8'hFF, 7'd2);
    send_tick();
    send_tick();
    send_tick();
    send_beat(lrwi_pkg::MODE_ARM,  8'd10, 8'd5,  7'd3);
    send_tick();
    send_tick();
    send_beat(lrwi_pkg::MODE_ARM,  8'd0,  8'hFB, 7'd2);
    send_tick();
    send_beat(lrwi_pkg::MODE_ARM,  8'h80, 8'h7F, 7'h7F);
    send_tick();
    send_beat(lrwi_pkg::MODE_ARM,  8'h7F, 8'h80, 7'd3);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_beat(lrwi_pkg::MODE_ARM,  8'd80, 8'd80, 7'd1);
    send_tick();
    send_tick();

    wait_drained();

    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      if (!drained_mid && beats_sent > target - RANDOM_BEATS / 4) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      if (holds_done == 0 && !hold_req && beats_sent > target - RANDOM_BEATS / 2)
        hold_req = 1'b1;
      if ($urandom_range(0, 9) == 0)
        send_beat(1'($urandom), lrwi_pkg::LEVEL_W'($urandom),
                  lrwi_pkg::LEVEL_W'($urandom), lrwi_pkg::LEN_W'($urandom));
      else
        send_ramp_run();
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.mismatches++;
      $display("%0d expected results never arrived", sb.pending());
    end

    $display("run covered %0d beats with %0d arms; %0d results checked", beats_sent,
             sb.arms, sb.results);
    $display("%0d ramps finished, %0d out-of-window results, %0d mismatches",
             sb.finishes, sb.out_of_range, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
